// ----- hdl/fmlf_pkg.sv -----
package fmlf_pkg;

    localparam int ADDR_W        = 16;
    localparam int LEN_W         = ADDR_W + 1;
    localparam int SYM_W         = 3;
    localparam int ALPHABET_SIZE = 5;
    localparam int RANK_W        = 16;
    localparam int ENTRY_W       = SYM_W + RANK_W;

    localparam logic [SYM_W-1:0] SYM_LIMIT = SYM_W'(ALPHABET_SIZE);

    // item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_WALK  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
    localparam logic [1:0] STATUS_RANGE      = 2'd2;
    localparam logic [1:0] STATUS_WALK_DONE  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SYM_W-1:0]  symbol;
        logic [ADDR_W-1:0] index;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lf_value;
        logic [SYM_W-1:0]  code_out;
        logic              walk_last;
        logic [1:0]        status;
    } result_t;

    // count update request from the control to the count unit
    typedef struct packed {
        logic             clear;
        logic             bump;
        logic [SYM_W-1:0] sym;
    } cnt_ctl_t;

endpackage

// ----- hdl/fmlf_ram.sv -----
module fmlf_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 19
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/fmlf_counts.sv -----
module fmlf_counts
    import fmlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cnt_ctl_t          ctl,
    input  logic [SYM_W-1:0]  query_sym,
    output logic [RANK_W-1:0] rank_out,
    output logic [ADDR_W-1:0] base_out
);

    // per-code counts and running prefix sums (codes strictly below)
    logic [LEN_W-1:0] cnt_reg  [ALPHABET_SIZE];
    logic [LEN_W-1:0] cnt_next [ALPHABET_SIZE];
    logic [LEN_W-1:0] base_reg [ALPHABET_SIZE];
    logic [LEN_W-1:0] base_next[ALPHABET_SIZE];

    always_comb
    begin
        for (int c = 0; c < ALPHABET_SIZE; c++)
        begin
            cnt_next[c]  = ctl.clear ? '0 : cnt_reg[c];
            base_next[c] = ctl.clear ? '0 : base_reg[c];
            if (ctl.bump && (SYM_W'(c) == ctl.sym))
            begin
                cnt_next[c] = cnt_next[c] + LEN_W'(1);
            end
            if (ctl.bump && (SYM_W'(c) > ctl.sym))
            begin
                base_next[c] = base_next[c] + LEN_W'(1);
            end
        end
    end

    // rank of the symbol being appended, zero when a new load starts
    always_comb
    begin
        rank_out = '0;
        for (int c = 0; c < ALPHABET_SIZE; c++)
        begin
            if (!ctl.clear && (SYM_W'(c) == ctl.sym))
            begin
                rank_out = cnt_reg[c][RANK_W-1:0];
            end
        end
    end

    always_comb
    begin
        base_out = '0;
        for (int c = 0; c < ALPHABET_SIZE; c++)
        begin
            if (SYM_W'(c) == query_sym)
            begin
                base_out = base_reg[c][ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < ALPHABET_SIZE; c++)
            begin
                cnt_reg[c]  <= '0;
                base_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < ALPHABET_SIZE; c++)
            begin
                cnt_reg[c]  <= cnt_next[c];
                base_reg[c] <= base_next[c];
            end
        end
    end

endmodule

// ----- hdl/fm_index_lf_mapper_top.sv -----
// channel   direction  handshake                  payload
// item      in         start high, busy low       item_t   (kind, symbol, index, last)
// result    out        done strobe, one cycle     result_t (lf_value, code_out, walk_last, status)
// config    in         cfg_valid and cfg_ready    cfg_data (end_row)
//
// a load transaction completes at its accept edge; busy stays low
// a query or walk reads the entry store at accept and finishes in the following lookup cycle,
//   since the read of the store is registered
// results are registered onto done in the cycle after they are computed; the receiver cannot stall
// reset clears counts, length, walk state and end_row; the entry store is not cleared
module fm_index_lf_mapper_top
    import fmlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;
    logic [1:0]        kind_reg, kind_next;
    logic [ADDR_W-1:0] index_reg, index_next;
    logic [ADDR_W-1:0] end_row_reg;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              loaded_reg, loaded_next;
    logic [ADDR_W-1:0] walk_pos_reg, walk_pos_next;
    logic [LEN_W-1:0]  steps_reg, steps_next;

    logic              accept;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  new_len;
    logic              load_drop;
    logic              is_load;

    cnt_ctl_t          cnt_ctl;
    logic [RANK_W-1:0] app_rank;
    logic [ADDR_W-1:0] base;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [SYM_W-1:0]  rd_sym;
    logic [RANK_W-1:0] rd_rank;
    logic [ADDR_W-1:0] lf;

    assign busy      = (state_reg == ST_LOOKUP);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // a load after a finished load starts over from an empty store
    assign is_load   = accept && (item.kind == KIND_LOAD);
    assign eff_len   = loaded_reg ? '0 : length_reg;
    assign load_drop = (item.symbol >= SYM_LIMIT) || eff_len[LEN_W-1];
    assign new_len   = load_drop ? eff_len : eff_len + LEN_W'(1);

    assign mem_we        = is_load && !load_drop;
    assign cnt_ctl.clear = is_load && loaded_reg;
    assign cnt_ctl.bump  = mem_we;
    assign cnt_ctl.sym   = item.symbol;

    // walks read at the current position, queries at the requested row;
    // writes only happen on load accepts, so a read never meets a write in flight
    assign mem_raddr = (item.kind == KIND_WALK) ? walk_pos_reg : item.index;

    assign rd_sym  = mem_rdata[ENTRY_W-1 -: SYM_W];
    assign rd_rank = mem_rdata[RANK_W-1:0];
    assign lf      = base + rd_rank;

    fmlf_counts u_counts (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cnt_ctl),
        .query_sym (rd_sym),
        .rank_out  (app_rank),
        .base_out  (base)
    );

    fmlf_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (eff_len[ADDR_W-1:0]),
        .wdata ({item.symbol, app_rank}),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        res_next      = '0;
        kind_next     = kind_reg;
        index_next    = index_reg;
        length_next   = length_reg;
        loaded_next   = loaded_reg;
        walk_pos_next = walk_pos_reg;
        steps_next    = steps_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = item.kind;
                    index_next = item.index;
                    case (item.kind)
                        KIND_LOAD:
                        begin
                            length_next = new_len;
                            if (loaded_reg)
                            begin
                                loaded_next   = 1'b0;
                                walk_pos_next = '0;
                                steps_next    = '0;
                            end
                            if (item.last)
                            begin
                                loaded_next   = 1'b1;
                                walk_pos_next = end_row_reg;
                                steps_next    = (new_len != '0) ? new_len - LEN_W'(1) : '0;
                            end
                            if (load_drop)
                            begin
                                done_next       = 1'b1;
                                res_next.status = STATUS_RANGE;
                            end
                        end
                        KIND_QUERY, KIND_WALK:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            // unused kind: accepted and dropped
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (!loaded_reg)
                begin
                    res_next.status = STATUS_NOT_LOADED;
                end
                else if (kind_reg == KIND_QUERY)
                begin
                    if ({1'b0, index_reg} >= length_reg)
                    begin
                        res_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        res_next.lf_value = lf;
                        res_next.code_out = rd_sym;
                    end
                end
                else if (steps_reg == '0)
                begin
                    res_next.status = STATUS_WALK_DONE;
                end
                else if ({1'b0, walk_pos_reg} >= length_reg)
                begin
                    // start row outside the loaded text: position and steps hold
                    res_next.status = STATUS_RANGE;
                end
                else
                begin
                    walk_pos_next      = lf;
                    steps_next         = steps_reg - LEN_W'(1);
                    res_next.lf_value  = lf;
                    res_next.code_out  = rd_sym;
                    res_next.walk_last = (steps_reg == LEN_W'(1));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            res_reg      <= '0;
            kind_reg     <= KIND_LOAD;
            index_reg    <= '0;
            end_row_reg  <= '0;
            length_reg   <= '0;
            loaded_reg   <= 1'b0;
            walk_pos_reg <= '0;
            steps_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            res_reg      <= res_next;
            kind_reg     <= kind_next;
            index_reg    <= index_next;
            length_reg   <= length_next;
            loaded_reg   <= loaded_next;
            walk_pos_reg <= walk_pos_next;
            steps_reg    <= steps_next;
            if (cfg_valid && cfg_ready)
            begin
                end_row_reg <= cfg_data;
            end
        end
    end

    // the lookup cycle only follows an accepted transaction
    a_busy_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> $past(start && !busy))
        else $error("lookup cycle without an accepted transaction");

    // a successful result is only given against a finished load
    a_ok_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_OK) |-> loaded_reg)
        else $error("ok result while no load is finished");

    // the final walk symbol leaves no steps behind
    a_walk_last_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.walk_last) |-> (steps_reg == '0))
        else $error("walk_last with steps remaining");

    // armed steps never reach the loaded length
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (steps_reg == '0) || (steps_reg < length_reg))
        else $error("walk steps beyond loaded length");

endmodule
